>>> hw/rtl/frame_lag_partition_score_assert.svh
// ----------------------------------------------------------------------------
// frame_lag_partition_score_assert.svh
// Assertion macros shared by the frame lag scoring block.
// ----------------------------------------------------------------------------
`ifndef FRAME_LAG_PARTITION_SCORE_ASSERT_SVH
`define FRAME_LAG_PARTITION_SCORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define FLPS_ASSERT_IMPLY(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define FLPS_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

>>> hw/rtl/flps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flps_pkg
// Widths, register indexes and shared types of the frame lag scoring block.
// ----------------------------------------------------------------------------
package flps_pkg;

  localparam int IN_W       = 16;  // capacity / weight field width
  localparam int LOAD_W     = 16;
  localparam int LANES      = 3;   // capacity * weight lanes
  localparam int LEVEL_W    = 8;
  localparam int FRAMES_W   = 16;
  localparam int POINTS_W   = 17;
  localparam int SQ_W       = 34;  // squared partition points
  localparam int SUMSQ_W    = 64;
  localparam int TOTAL_W    = 24;
  localparam int MS_W       = 35;
  localparam int RMS_W      = 26;
  localparam int RAD_W      = 2 * RMS_W;
  localparam int FRAC_W     = 8;   // root fraction bits
  localparam int DIV_DVD_W  = 64;
  localparam int STEP_W     = 7;   // divider step count, up to DIV_DVD_W
  localparam int ROOT_CNT_W = 5;   // root step count, up to RMS_W

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int S_TDATA_W  = 2 * LANES * IN_W + LOAD_W;
  localparam int M_TDATA_W  = 96;
  localparam int M_TUSER_W  = 2;
  localparam int M_PAD_W    = M_TDATA_W - (1 + LEVEL_W + TOTAL_W + MS_W + RMS_W);

  localparam logic [CFG_IDX_W-1:0] REG_ENOUGH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PART_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ONE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TWO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 3'd5;

  // status of a multi-cycle arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;  // one-cycle pulse, result stable from here on
  } unit_sts_t;

endpackage

>>> hw/rtl/flps_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flps_lane
// One capacity lane: registered product of a window capacity and its weight.
// ----------------------------------------------------------------------------
module flps_lane #(
  parameter int CAP_W = 16
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [CAP_W-1:0]                      capacity,
  input  logic [flps_pkg::IN_W-1:0]             weight,
  output logic [CAP_W+flps_pkg::IN_W-1:0]       product
);
  import flps_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      product <= (CAP_W + IN_W)'(capacity) * (CAP_W + IN_W)'(weight);
    end
  end

endmodule

>>> hw/rtl/flps_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flps_div
// Restoring divider, one quotient bit per cycle. The dividend comes in
// left-aligned so that only the given number of steps is run.
// ----------------------------------------------------------------------------
module flps_div #(
  parameter int DSR_W = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [flps_pkg::DIV_DVD_W-1:0]   dividend,
  input  logic [DSR_W-1:0]                 divisor,
  input  logic [flps_pkg::STEP_W-1:0]      steps,
  output logic [flps_pkg::DIV_DVD_W-1:0]   quotient,
  output flps_pkg::unit_sts_t              sts
);
  import flps_pkg::*;

  logic [STEP_W-1:0]    cnt;
  logic                 done;
  logic [DIV_DVD_W-1:0] dvd;
  logic [DSR_W-1:0]     rem;
  logic [DSR_W-1:0]     dsr;
  logic [DSR_W:0]       trial;
  logic [DSR_W:0]       diff;
  logic                 fits;

  assign trial = {rem, dvd[DIV_DVD_W-1]};
  assign fits  = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= steps;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in at the bottom as the dividend shifts out the top
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (cnt != '0) begin
      rem <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      dvd <= {dvd[DIV_DVD_W-2:0], fits};
    end
  end

  assign quotient = dvd;
  assign sts.busy = cnt != '0;
  assign sts.done = done;

endmodule

>>> hw/rtl/flps_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flps_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module flps_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [flps_pkg::RAD_W-1:0]    radicand,
  output logic [flps_pkg::RMS_W-1:0]    root,
  output flps_pkg::unit_sts_t           sts
);
  import flps_pkg::*;

  localparam int REM_W = RMS_W + 2;

  logic [ROOT_CNT_W-1:0] cnt;
  logic                  done;
  logic [RAD_W-1:0]      rad;
  logic [REM_W-1:0]      rem;
  logic [REM_W+1:0]      trial;
  logic [REM_W+1:0]      test;
  logic [REM_W+1:0]      diff;
  logic                  fits;

  // bring down two radicand bits, try root*4+1
  assign trial = {rem, rad[RAD_W-1 -: 2]};
  assign test  = {2'b00, root, 2'b01};
  assign fits  = trial >= test;
  assign diff  = trial - test;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= ROOT_CNT_W'(RMS_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == ROOT_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (cnt != '0) begin
      rem  <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
      root <= {root[RMS_W-2:0], fits};
      rad  <= {rad[RAD_W-3:0], 2'b00};
    end
  end

  assign sts.busy = cnt != '0;
  assign sts.done = done;

endmodule

>>> hw/rtl/frame_lag_partition_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_lag_partition_score
// Per-frame lag judgment with partition point scoring; on the last frame of a
// run it reports the mean square of partition points and its Q.8 root.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata: frame record, s_tlast: last frame
//  m_*      out  m_tvalid/m_tready  m_tdata: lag and score, m_tuser: flags
//  cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data: register write
//
//  One word at a time. A normal frame is paced by the serial divider of the
//  weighted capacity sum, one quotient bit per cycle. A last frame with
//  complete partitions adds 64 steps of the same divider for the mean
//  square and 26 steps of the root unit.
//  The result sits in an output register; a new word is accepted while it
//  waits, and the block stalls before its own result if it is still held.
//  rst is synchronous; state clears at once, no clearing pass.
// ----------------------------------------------------------------------------
`include "frame_lag_partition_score_assert.svh"

module frame_lag_partition_score #(
  parameter int CAPACITY_BITS        = 16,
  parameter int PARTITION_COUNT_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  // capacity_a, capacity_b, capacity_c, weight_a, weight_b, weight_c,
  // required load (16 bits each)
  input  logic [flps_pkg::S_TDATA_W-1:0]     s_tdata,
  input  logic                               s_tlast,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // frame_lagged, lag_level, partition_total, mean_square, rms_q8, zero pad
  output logic [flps_pkg::M_TDATA_W-1:0]     m_tdata,
  // score_valid, no_partition
  output logic [flps_pkg::M_TUSER_W-1:0]     m_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [flps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [flps_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import flps_pkg::*;

  localparam int CAP_W  = (CAPACITY_BITS < IN_W) ? CAPACITY_BITS : IN_W;
  localparam int PROD_W = CAP_W + IN_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int CNT_W  = PARTITION_COUNT_BITS;
  localparam int DIV_W  = (PARTITION_COUNT_BITS > IN_W) ? PARTITION_COUNT_BITS : IN_W;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL    = 4'd1;
  localparam logic [3:0] ST_SUM    = 4'd2;
  localparam logic [3:0] ST_QSTART = 4'd3;
  localparam logic [3:0] ST_QDIV   = 4'd4;
  localparam logic [3:0] ST_LEVEL  = 4'd5;
  localparam logic [3:0] ST_SQUARE = 4'd6;
  localparam logic [3:0] ST_ACCUM  = 4'd7;
  localparam logic [3:0] ST_SCORE  = 4'd8;
  localparam logic [3:0] ST_MDIV   = 4'd9;
  localparam logic [3:0] ST_ROOT   = 4'd10;
  localparam logic [3:0] ST_OUT    = 4'd11;

  // configuration
  logic [IN_W-1:0]    enough_cap;
  logic [IN_W-1:0]    frame_quantum;
  logic [FRAMES_W-1:0] partition_length;
  logic [LEVEL_W-1:0] lag_level_one;
  logic [LEVEL_W-1:0] lag_level_two;
  logic [LEVEL_W-1:0] lag_ceiling;

  // scoring state
  logic [LEVEL_W-1:0]  recent_lag;
  logic [FRAMES_W-1:0] frames_in_partition;
  logic [POINTS_W-1:0] partition_points;
  logic [SUMSQ_W-1:0]  square_sum;
  logic [CNT_W-1:0]    partitions_seen;

  logic [3:0]          state;
  logic [3:0]          state_next;

  // captured word and pipeline
  logic [CAP_W-1:0]    lane_cap [LANES];
  logic [IN_W-1:0]     lane_wgt [LANES];
  logic [PROD_W-1:0]   lane_prod [LANES];
  logic [LOAD_W-1:0]   need_load;
  logic                last_frame;
  logic [SUM_W-1:0]    cap_sum;
  logic                lag_q;
  logic [LEVEL_W-1:0]  level_q;
  logic                complete_q;
  logic [POINTS_W-1:0] points_done;
  logic [SQ_W-1:0]     points_sq;

  // output register
  logic                out_lagged;
  logic [LEVEL_W-1:0]  out_level;
  logic                out_score;
  logic                out_nopart;
  logic [TOTAL_W-1:0]  out_total;
  logic [MS_W-1:0]     out_ms;
  logic [RMS_W-1:0]    out_rms;

  // arithmetic units
  logic                 div_start;
  logic [DIV_DVD_W-1:0] div_dividend;
  logic [DIV_W-1:0]     div_divisor;
  logic [STEP_W-1:0]    div_steps;
  logic [DIV_DVD_W-1:0] div_q;
  unit_sts_t            div_sts;
  logic                 root_start;
  logic [RAD_W-1:0]     root_rad;
  logic [RMS_W-1:0]     root_val;
  unit_sts_t            root_sts;

  // frame judgment
  logic [SUM_W-1:0]    provided;
  logic                lag;
  logic [LEVEL_W-1:0]  level_base;
  logic [LEVEL_W:0]    level_inc;
  logic [LEVEL_W-1:0]  level_new;
  logic [1:0]          points_add;
  logic [POINTS_W-1:0] points_new;
  logic [FRAMES_W-1:0] frames_inc;
  logic [FRAMES_W-1:0] plen;
  logic                complete;
  logic [IN_W-1:0]     quantum;
  logic [SUMSQ_W:0]    square_acc;
  logic                have_score;
  logic [31:0]         partitions_wide;
  logic                out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = state == ST_IDLE;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enough_cap       <= 16'hFFFF;
      frame_quantum    <= 16'd1;
      partition_length <= 16'd64;
      lag_level_one    <= 8'd1;
      lag_level_two    <= 8'd2;
      lag_ceiling      <= 8'hFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ENOUGH:    enough_cap       <= cfg_data;
        REG_QUANTUM:   frame_quantum    <= cfg_data;
        REG_PART_LEN:  partition_length <= cfg_data;
        REG_LEVEL_ONE: lag_level_one    <= cfg_data[LEVEL_W-1:0];
        REG_LEVEL_TWO: lag_level_two    <= cfg_data[LEVEL_W-1:0];
        REG_CEILING:   lag_ceiling      <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      for (int i = 0; i < LANES; i++) begin
        lane_cap[i] <= s_tdata[i*IN_W +: CAP_W];
        lane_wgt[i] <= s_tdata[(LANES+i)*IN_W +: IN_W];
      end
      need_load  <= s_tdata[2*LANES*IN_W +: LOAD_W];
      last_frame <= s_tlast;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    flps_lane #(
      .CAP_W(CAP_W)
    ) u_lane (
      .clk      (clk),
      .en       (state == ST_MUL),
      .capacity (lane_cap[g]),
      .weight   (lane_wgt[g]),
      .product  (lane_prod[g])
    );
  end

  // merge the lanes
  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      cap_sum <= SUM_W'(lane_prod[0]) + SUM_W'(lane_prod[1]) + SUM_W'(lane_prod[2]);
    end
  end

  assign quantum = (frame_quantum == '0) ? IN_W'(1) : frame_quantum;

  // one divider serves the per-frame capacity and the final mean square
  always_comb begin
    div_start = 1'b0;
    if (state == ST_QSTART) begin
      div_start = 1'b1;
    end else if (state == ST_SCORE && last_frame && partitions_seen != '0) begin
      div_start = 1'b1;
    end
    if (state == ST_SCORE) begin
      div_dividend = square_sum;
      div_divisor  = DIV_W'(partitions_seen);
      div_steps    = STEP_W'(DIV_DVD_W);
    end else begin
      div_dividend = {cap_sum, {(DIV_DVD_W - SUM_W){1'b0}}};
      div_divisor  = DIV_W'(quantum);
      div_steps    = STEP_W'(SUM_W);
    end
  end

  flps_div #(
    .DSR_W(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .quotient (div_q),
    .sts      (div_sts)
  );

  assign root_start = state == ST_MDIV && div_sts.done;
  assign root_rad   = {1'b0, div_q[MS_W-1:0], {(2*FRAC_W){1'b0}}};

  flps_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (root_rad),
    .root     (root_val),
    .sts      (root_sts)
  );

  always_comb begin
    provided   = div_q[SUM_W-1:0];
    lag        = provided < SUM_W'(need_load) && provided < SUM_W'(enough_cap);
    level_base = lag ? recent_lag : (recent_lag >> 1);
    level_inc  = {1'b0, level_base} + (LEVEL_W + 1)'(lag);
    level_new  = (level_inc > {1'b0, lag_ceiling}) ? lag_ceiling : level_inc[LEVEL_W-1:0];
    points_add = 2'(level_new >= lag_level_one) + 2'(level_new >= lag_level_two);
    points_new = partition_points + POINTS_W'(points_add);
    frames_inc = frames_in_partition + 1'b1;
    plen       = (partition_length == '0) ? FRAMES_W'(1) : partition_length;
    complete   = frames_inc >= plen;
  end

  always_ff @(posedge clk) begin
    if (state == ST_LEVEL) begin
      lag_q       <= lag;
      level_q     <= level_new;
      complete_q  <= complete;
      points_done <= points_new;
    end
    if (state == ST_SQUARE) begin
      points_sq <= SQ_W'(points_done) * SQ_W'(points_done);
    end
  end

  assign square_acc = {1'b0, square_sum} + (SUMSQ_W + 1)'(points_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_lag          <= '0;
      frames_in_partition <= '0;
      partition_points    <= '0;
      square_sum          <= '0;
      partitions_seen     <= '0;
    end else begin
      unique case (state)
        ST_LEVEL: begin
          recent_lag <= level_new;
          if (complete) begin
            partition_points    <= '0;
            frames_in_partition <= '0;
          end else begin
            partition_points    <= points_new;
            frames_in_partition <= frames_inc;
          end
        end
        ST_ACCUM: begin
          if (complete_q) begin
            square_sum <= square_acc[SUMSQ_W] ? '1 : square_acc[SUMSQ_W-1:0];
            if (partitions_seen != '1) begin
              partitions_seen <= partitions_seen + 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (out_free && last_frame) begin
            recent_lag          <= '0;
            frames_in_partition <= '0;
            partition_points    <= '0;
            square_sum          <= '0;
            partitions_seen     <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_MUL;
      ST_MUL:    state_next = ST_SUM;
      ST_SUM:    state_next = ST_QSTART;
      ST_QSTART: state_next = ST_QDIV;
      ST_QDIV:   if (div_sts.done) state_next = ST_LEVEL;
      ST_LEVEL:  state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_ACCUM;
      ST_ACCUM:  state_next = ST_SCORE;
      ST_SCORE:  state_next = div_start ? ST_MDIV : ST_OUT;
      ST_MDIV:   if (div_sts.done) state_next = ST_ROOT;
      ST_ROOT:   if (root_sts.done) state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign have_score      = last_frame && partitions_seen != '0;
  assign partitions_wide = 32'(partitions_seen);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_lagged <= lag_q;
      out_level  <= level_q;
      out_score  <= last_frame;
      out_nopart <= last_frame && partitions_seen == '0;
      out_total  <= have_score ? partitions_wide[TOTAL_W-1:0] : '0;
      out_ms     <= have_score ? div_q[MS_W-1:0] : '0;
      out_rms    <= have_score ? root_val : '0;
    end
  end

  assign m_tdata = {{M_PAD_W{1'b0}}, out_rms, out_ms, out_total, out_level, out_lagged};
  assign m_tuser = {out_nopart, out_score};

  `FLPS_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state == ST_MUL,
    "accepted word did not start the lanes")
  `FLPS_ASSERT_IMPLY(a_units_apart, div_sts.busy, !root_sts.busy,
    "divider and root unit busy together")
  `FLPS_ASSERT_IMPLY(a_level_capped, state == ST_SQUARE, recent_lag <= lag_ceiling,
    "lag level above ceiling")
  `FLPS_ASSERT_IMPLY(a_nopart_empty, m_tvalid && out_nopart,
    out_score && out_ms == '0 && out_rms == '0 && out_total == '0,
    "no-partition result carries a score")

endmodule
